### sv/gpe_pkg.sv
`timescale 1ns / 1ps

package gpe_pkg;

    // fixed field widths
    localparam int CODE_W  = 6;
    localparam int HAP_W   = 3;
    localparam int PAIR_W  = 2 * HAP_W;
    localparam int PHASE_W = 6;
    localparam int SNP_W   = 2;

    // per-SNP genotype codes
    localparam logic [1:0] GT_MISSING = 2'd0;
    localparam logic [1:0] GT_HOM1    = 2'd1;
    localparam logic [1:0] GT_HET     = 2'd2;
    localparam logic [1:0] GT_HOM2    = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAD,
        ST_RD,
        ST_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    // one result word
    typedef struct packed {
        logic [HAP_W-1:0]   first_hap;
        logic [HAP_W-1:0]   second_hap;
        logic [PHASE_W-1:0] phase_count;
        logic               last;
        logic               bad_code;
    } t_word;

endpackage

### sv/gpe_pair_ram.sv
`timescale 1ns / 1ps

module gpe_pair_ram #(
    parameter int DEPTH = 36,
    parameter int AW    = 6,
    parameter int W     = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/gpe_ctrl.sv
`timescale 1ns / 1ps

module gpe_ctrl #(
    parameter int MAX_SNPS  = 3,
    parameter int MAX_PAIRS = 36,
    parameter int AW        = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [gpe_pkg::CODE_W-1:0]   i_code,
    input  logic [gpe_pkg::SNP_W-1:0]    i_snp_cfg,
    input  logic                         i_slot_free,
    output logic                         o_load,
    output gpe_pkg::t_word               o_word,
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [gpe_pkg::PAIR_W-1:0]   o_wdata,
    output logic                         o_re,
    output logic [AW-1:0]                o_raddr,
    input  logic [gpe_pkg::PAIR_W-1:0]   i_rdata
);

    import gpe_pkg::*;

    localparam int CW = $clog2(MAX_PAIRS + 1);

    t_state              r_state, n_state;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [SNP_W-1:0]    r_snps, n_snps;
    logic [SNP_W-1:0]    r_snp, n_snp;
    logic [CW-1:0]       r_j, n_j;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_m, n_m;
    logic [1:0]          r_step, n_step;

    logic [SNP_W-1:0]    snps_in;
    logic                bad_in;
    logic [1:0]          gt;
    logic [HAP_W-1:0]    bmask, h1, h2;
    logic                pair_last;
    logic                room;
    logic                app, rew, done;
    logic [PAIR_W-1:0]   pair_word;

    // SNPs in use, saturated
    assign snps_in = (i_snp_cfg > SNP_W'(MAX_SNPS)) ? SNP_W'(MAX_SNPS) : i_snp_cfg;
    assign bad_in  = (i_code == '0) || ((i_code >> {snps_in, 1'b0}) != '0);

    // current SNP genotype and pair under work
    assign gt        = 2'(r_code >> {r_snp, 1'b0});
    assign bmask     = HAP_W'(1) << r_snp;
    assign h1        = i_rdata[HAP_W-1:0];
    assign h2        = i_rdata[PAIR_W-1:HAP_W];
    assign pair_last = (r_j + CW'(1)) == r_n;
    assign room      = r_m < CW'(MAX_PAIRS);

    // per-pair write schedule: at most one write a step
    always_comb begin
        app       = 1'b0;
        rew       = 1'b0;
        done      = 1'b0;
        pair_word = {h2, h1};
        case (gt)
            GT_MISSING: begin
                case (r_step)
                    2'd0: begin
                        app       = 1'b1;
                        pair_word = {h2 | bmask, h1 | bmask};
                    end
                    2'd1: begin
                        app       = 1'b1;
                        pair_word = {h2 | bmask, h1};
                    end
                    default: begin
                        app       = (h1 != h2);
                        pair_word = {h2, h1 | bmask};
                        done      = 1'b1;
                    end
                endcase
            end
            GT_HOM1: begin
                done = 1'b1;
            end
            GT_HET: begin
                if (r_step == 2'd0) begin
                    rew       = 1'b1;
                    pair_word = {h2 | bmask, h1};
                end else begin
                    app       = (h1 != h2);
                    pair_word = {h2, h1 | bmask};
                    done      = 1'b1;
                end
            end
            default: begin
                rew       = 1'b1;
                pair_word = {h2 | bmask, h1 | bmask};
                done      = 1'b1;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_m     <= '0;
            r_j     <= '0;
            r_snp   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_m     <= n_m;
            r_j     <= n_j;
            r_snp   <= n_snp;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_snps <= n_snps;
    end

    // next state and outputs
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_snps  = r_snps;
        n_snp   = r_snp;
        n_j     = r_j;
        n_n     = r_n;
        n_m     = r_m;
        n_step  = r_step;
        o_ready = 1'b0;
        o_load  = 1'b0;
        o_word  = '0;
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = '0;
        o_re    = 1'b0;
        o_raddr = r_j[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_code = i_code;
                    n_snps = snps_in;
                    if (bad_in) begin
                        n_n     = '0;
                        n_state = ST_BAD;
                    end else begin
                        // seed list with pair (0,0)
                        o_we    = 1'b1;
                        n_n     = CW'(1);
                        n_m     = CW'(1);
                        n_j     = '0;
                        n_snp   = '0;
                        n_step  = '0;
                        n_state = ST_RD;
                    end
                end
            end
            ST_BAD: begin
                if (i_slot_free) begin
                    o_load         = 1'b1;
                    o_word.last    = 1'b1;
                    o_word.bad_code = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_RD: begin
                o_re    = 1'b1;
                n_step  = '0;
                n_state = ST_WR;
            end
            ST_WR: begin
                o_wdata = pair_word;
                if (rew) begin
                    o_we    = 1'b1;
                    o_waddr = r_j[AW-1:0];
                end else if (app && room) begin
                    o_we    = 1'b1;
                    o_waddr = r_m[AW-1:0];
                    n_m     = r_m + CW'(1);
                end
                n_step = r_step + 2'd1;
                if (done) begin
                    n_step = '0;
                    if (pair_last) begin
                        // SNP finished: appended pairs join the list
                        n_n   = n_m;
                        n_j   = '0;
                        n_snp = r_snp + SNP_W'(1);
                        if ((r_snp + SNP_W'(1)) == r_snps) begin
                            n_state = ST_EMIT_RD;
                        end else begin
                            n_state = ST_RD;
                        end
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = ST_RD;
                    end
                end
            end
            ST_EMIT_RD: begin
                o_re    = 1'b1;
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (i_slot_free) begin
                    o_load             = 1'b1;
                    o_word.first_hap   = h1;
                    o_word.second_hap  = h2;
                    o_word.phase_count = PHASE_W'(r_n);
                    o_word.last        = pair_last;
                    if (pair_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/genotype_phase_enumerator_unit.sv
`timescale 1ns / 1ps
// Genotype phase enumerator.
// Input channel (i_valid / o_ready) takes one unphased genotype code, two bits
// per SNP. Output channel (o_valid / i_ready) returns every phased haplotype
// pair for that code, one word per pair, each with the pair count, and a last
// flag on the final word. A zero code, or one with bits above the SNPs in use,
// returns a single word with bad_code set.
// i_cfg_wr_en / i_cfg_wr_data write snp_count; write only while idle.
// The pair list lives in a single-port-write RAM. Each SNP pass reads every
// stored pair, then rewrites it and appends new pairs. Each result word is
// read from the RAM and then loaded into the output register. A bad code's
// word is loaded from the ST_BAD state once the output register is free.
// One code is in flight at a time; a new code is taken as soon as the last
// word sits in the output register, even while that word is still stalled.
// When the receiver stalls, the output register holds its word and the
// sequencer waits. Reset clears the sequencer and output valid and sets
// snp_count to 3; the RAM is not cleared and needs no clearing pass.
module genotype_phase_enumerator_unit #(
    parameter int MAX_SNPS  = 3,
    parameter int MAX_PAIRS = 36
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [gpe_pkg::SNP_W-1:0]     i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gpe_pkg::CODE_W-1:0]    i_genotype_code,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gpe_pkg::HAP_W-1:0]     o_first_hap,
    output logic [gpe_pkg::HAP_W-1:0]     o_second_hap,
    output logic [gpe_pkg::PHASE_W-1:0]   o_phase_count,
    output logic                          o_last,
    output logic                          o_bad_code
);

    import gpe_pkg::*;

    localparam int AW = $clog2(MAX_PAIRS);

    logic [SNP_W-1:0]  r_snp_count;
    logic              r_o_valid;
    t_word             r_out;
    logic              slot_free;
    logic              load;
    t_word             word;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [PAIR_W-1:0] wdata, rdata;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snp_count <= SNP_W'(3);
        end else if (i_cfg_wr_en) begin
            r_snp_count <= i_cfg_wr_data;
        end
    end

    gpe_pair_ram #(
        .DEPTH (MAX_PAIRS),
        .AW    (AW),
        .W     (PAIR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    gpe_ctrl #(
        .MAX_SNPS  (MAX_SNPS),
        .MAX_PAIRS (MAX_PAIRS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_code      (i_genotype_code),
        .i_snp_cfg   (r_snp_count),
        .i_slot_free (slot_free),
        .o_load      (load),
        .o_word      (word),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // output register
    assign slot_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= word;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_first_hap   = r_out.first_hap;
    assign o_second_hap  = r_out.second_hap;
    assign o_phase_count = r_out.phase_count;
    assign o_last        = r_out.last;
    assign o_bad_code    = r_out.bad_code;

endmodule
